### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by positional_list_queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside of reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_CHK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg
// types and constants of the positional list queue
// ----------------------------------------------------------------------------
package plq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned POS_WIDTH  = 5;
  localparam int unsigned CNT_WIDTH  = $clog2(DEPTH + 1);
  localparam int unsigned SLOT_WIDTH = $clog2(DEPTH);
  localparam int unsigned CMP_WIDTH  = POS_WIDTH + 1;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_POP    = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    req_e                          req_type;
    logic [POS_WIDTH-1:0]          position;
    logic signed [DATA_WIDTH-1:0]  value_in;
  } in_word_t;

  typedef struct packed {
    status_e                       status;
    logic signed [DATA_WIDTH-1:0]  value_out;
    logic [CNT_WIDTH-1:0]          item_count;
    logic                          is_empty;
  } out_word_t;

  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [SLOT_WIDTH-1:0] slot;
  } op_t;

endpackage

### rtl/positional_list_queue.sv
// ----------------------------------------------------------------------------
// positional_list_queue
// ordered list of signed words with append, indexed insert, pop and remove
// ----------------------------------------------------------------------------
//  channel | ports                              | payload
//  --------+------------------------------------+-------------------------
//  request | in_valid_i, in_ready_o, in_word_i  | req_type, position, value
//  result  | out_valid_o, out_ready_i, out_word_o | status, word, count
//
//  a word is held in the input register, then decode and cell shift
//  write the list and the result register
//  one word per cycle sustained while the result side is not stalled
//  reset empties the list at once, no clearing pass
//  a stalled result holds the input register; the request side stalls after
// ----------------------------------------------------------------------------
module positional_list_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plq_pkg::out_word_t  out_word_o
);
  import plq_pkg::*;

`include "assert_macros.svh"

  logic                   in_valid_q;
  in_word_t               in_word_q;
  logic                   out_valid_q;
  out_word_t              out_word_q;
  out_word_t              out_word_d;
  logic                   advance;
  logic                   fire;
  status_e                status;
  op_t                    op;
  logic [CNT_WIDTH-1:0]   count;
  logic [CNT_WIDTH-1:0]   count_next;
  logic [DATA_WIDTH-1:0]  removed;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  plq_decode u_decode (
    .req_i    (in_word_q),
    .count_i  (count),
    .status_o (status),
    .op_o     (op)
  );

  plq_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .op_i         (op),
    .value_i      (in_word_q.value_in),
    .count_o      (count),
    .count_next_o (count_next),
    .removed_o    (removed)
  );

  always_comb begin
    out_word_d.status     = status;
    out_word_d.value_out  = removed;
    out_word_d.item_count = count_next;
    out_word_d.is_empty   = (count_next == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_CHK_NR(a_rst_no_result, !rst_ni |=> !out_valid_q, "result valid during reset")
  `ASSERT_CHK(a_fire_gives_result, fire |=> out_valid_q, "processed word gave no result")
  `ASSERT_CHK(a_count_bound, out_valid_q |-> out_word_q.item_count <= CNT_WIDTH'(DEPTH),
    "count above depth")
  `ASSERT_CHK(a_empty_flag,
    out_valid_q |-> out_word_q.is_empty == (out_word_q.item_count == '0),
    "empty flag disagrees with count")
  `ASSERT_CHK(a_flagged_zero,
    out_valid_q && out_word_q.status != ST_OK |-> out_word_q.value_out == '0,
    "flagged request returned a word")

endmodule

### rtl/plq_decode.sv
// ----------------------------------------------------------------------------
// plq_decode
// checks a request against the fill level and picks the slot to change
// ----------------------------------------------------------------------------
module plq_decode (
  input  plq_pkg::in_word_t              req_i,
  input  logic [plq_pkg::CNT_WIDTH-1:0]  count_i,
  output plq_pkg::status_e               status_o,
  output plq_pkg::op_t                   op_o
);
  import plq_pkg::*;

  logic                  full;
  logic                  empty;
  logic                  pos_zero;
  logic [CMP_WIDTH-1:0]  pos_ext;
  logic [CMP_WIDTH-1:0]  cnt_ext;
  logic [POS_WIDTH-1:0]  pos_m1;

  assign full     = (count_i == CNT_WIDTH'(DEPTH));
  assign empty    = (count_i == '0);
  assign pos_zero = (req_i.position == '0);
  assign pos_ext  = CMP_WIDTH'(req_i.position);
  assign cnt_ext  = CMP_WIDTH'(count_i);
  assign pos_m1   = req_i.position - POS_WIDTH'(1);

  always_comb begin
    status_o = ST_OK;
    op_o     = '0;
    case (req_i.req_type)
      REQ_APPEND: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          op_o.ins  = 1'b1;
          op_o.slot = count_i[SLOT_WIDTH-1:0];
        end
      end
      REQ_INSERT: begin
        if (full) begin
          status_o = ST_FULL;
        end else if (pos_zero || (pos_ext > cnt_ext + CMP_WIDTH'(1))) begin
          status_o = ST_BAD_POS;
        end else begin
          op_o.ins  = 1'b1;
          op_o.slot = pos_m1[SLOT_WIDTH-1:0];
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          op_o.rem  = 1'b1;
          op_o.slot = '0;
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else if (pos_zero || (pos_ext > cnt_ext)) begin
          status_o = ST_BAD_POS;
        end else begin
          op_o.rem  = 1'b1;
          op_o.slot = pos_m1[SLOT_WIDTH-1:0];
        end
      end
      default: begin
        status_o = ST_OK;
        op_o     = '0;
      end
    endcase
  end

endmodule

### rtl/plq_store.sv
// ----------------------------------------------------------------------------
// plq_store
// row of list cells with the fill count; each cell picks its shift from its own index
// ----------------------------------------------------------------------------
module plq_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  plq_pkg::op_t                    op_i,
  input  logic [plq_pkg::DATA_WIDTH-1:0]  value_i,
  output logic [plq_pkg::CNT_WIDTH-1:0]   count_o,
  output logic [plq_pkg::CNT_WIDTH-1:0]   count_next_o,
  output logic [plq_pkg::DATA_WIDTH-1:0]  removed_o
);
  import plq_pkg::*;

  logic [DATA_WIDTH-1:0] entry_q [DEPTH];
  logic [DATA_WIDTH-1:0] entry_d [DEPTH];
  logic [CNT_WIDTH-1:0]  count_q;
  logic [CNT_WIDTH-1:0]  count_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] from_left;
    logic [DATA_WIDTH-1:0] from_right;
    logic                  above;
    logic                  at;

    if (i == 0) begin : g_first
      assign from_left = entry_q[i];
    end else begin : g_mid
      assign from_left = entry_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign from_right = entry_q[i];
    end else begin : g_rest
      assign from_right = entry_q[i+1];
    end

    assign at    = (op_i.slot == SLOT_WIDTH'(i));
    assign above = (SLOT_WIDTH'(i) > op_i.slot);

    always_comb begin
      entry_d[i] = entry_q[i];
      if (op_i.ins) begin
        if (at) begin
          entry_d[i] = value_i;
        end else if (above) begin
          entry_d[i] = from_left;
        end
      end else if (op_i.rem) begin
        if (at || above) begin
          entry_d[i] = from_right;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (fire_i && (op_i.ins || op_i.rem)) begin
        entry_q[i] <= entry_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (op_i.ins) begin
      count_d = count_q + CNT_WIDTH'(1);
    end else if (op_i.rem) begin
      count_d = count_q - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;
  assign removed_o    = op_i.rem ? entry_q[op_i.slot] : '0;

endmodule

### bench/positional_list_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_queue_tb
// drives append, indexed insert, pop and remove requests into the list queue
// through valid/ready with bursty requests and a stalling result side, keeps
// a shadow copy of the list to predict every result word and compares each
// accepted result field by field in order
// ----------------------------------------------------------------------------
module positional_list_queue_tb;
  import plq_pkg::*;

  class list_shadow;
    logic signed [DATA_WIDTH-1:0] held[$];
    out_word_t                    pending_results[$];
    int unsigned                  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned held_count();
      return held.size();
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void note_request(in_word_t w);
      out_word_t r;
      int unsigned slot;
      r.status    = ST_OK;
      r.value_out = '0;
      slot        = w.position;
      case (w.req_type)
        REQ_APPEND: begin
          if (held.size() >= DEPTH) r.status = ST_FULL;
          else held.push_back(w.value_in);
        end
        REQ_INSERT: begin
          if (held.size() >= DEPTH) r.status = ST_FULL;
          else if (slot == 0 || slot > held.size() + 1) r.status = ST_BAD_POS;
          else held.insert(slot - 1, w.value_in);
        end
        REQ_POP: begin
          if (held.size() == 0) r.status = ST_EMPTY;
          else r.value_out = held.pop_front();
        end
        default: begin
          if (held.size() == 0) r.status = ST_EMPTY;
          else if (slot == 0 || slot > held.size()) r.status = ST_BAD_POS;
          else begin
            r.value_out = held[slot - 1];
            held.delete(slot - 1);
          end
        end
      endcase
      r.item_count = CNT_WIDTH'(held.size());
      r.is_empty   = (held.size() == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $error("result word with none pending");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
        mismatches++;
      end
      if (got.item_count !== want.item_count) begin
        $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  list_shadow shadow;

  positional_list_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic offer_request(in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_request(w);
    @(negedge clk_i);
  endtask

  task automatic issue(req_e op, int unsigned pos, logic signed [DATA_WIDTH-1:0] v);
    in_word_t w;
    w.req_type = op;
    w.position = POS_WIDTH'(pos);
    w.value_in = v;
    offer_request(w);
  endtask

  // trend 0 grows the list, 1 drains it, 2 stays balanced
  function automatic in_word_t random_request(int unsigned trend, int unsigned held_now);
    in_word_t    w;
    int unsigned roll;
    int unsigned pos;
    logic        grow;
    roll = $urandom_range(0, 99);
    grow = (trend == 0) ? (roll < 75) : (trend == 1) ? (roll < 25) : (roll < 50);
    if (grow) w.req_type = $urandom_range(0, 1) ? REQ_INSERT : REQ_APPEND;
    else w.req_type = $urandom_range(0, 1) ? REQ_REMOVE : REQ_POP;
    roll = $urandom_range(0, 99);
    if (roll < 5 || w.req_type == REQ_APPEND || w.req_type == REQ_POP) begin
      pos = $urandom_range(0, 31);
    end else if (w.req_type == REQ_INSERT) begin
      if (roll < 85) pos = $urandom_range(1, held_now + 1);
      else pos = $urandom_range(0, 1) ? 0 : $urandom_range(held_now + 2, 31);
    end else begin
      if (roll < 85) pos = $urandom_range(1, (held_now == 0) ? 1 : held_now);
      else pos = $urandom_range(0, 1) ? 0 : $urandom_range(held_now + 1, 31);
    end
    w.position = POS_WIDTH'(pos);
    case ($urandom_range(0, 39))
      0:       w.value_in = 32'h8000_0000;
      1:       w.value_in = 32'h7fff_ffff;
      2:       w.value_in = '0;
      3:       w.value_in = '1;
      default: w.value_in = $urandom;
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) shadow.check_result(out_word_o);
  end

  // result side stall pattern, with one long hold-off to back the block up
  initial begin
    int unsigned cyc;
    int unsigned style;
    int unsigned left;
    cyc  = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(16, 96);
      end
      left--;
      if (cyc >= 500 && cyc < 900) out_ready_i <= 1'b0;
      else begin
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= (cyc % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned trend;
    int unsigned trend_left;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned wait_cycles;
    shadow = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, bad positions, extremes, full list
    issue(REQ_POP,    0,  32'sd5);
    issue(REQ_REMOVE, 31, 32'sd0);
    issue(REQ_INSERT, 0,  32'sd7);
    issue(REQ_INSERT, 2,  32'sd7);
    issue(REQ_INSERT, 1,  32'h8000_0000);
    issue(REQ_APPEND, 17, 32'h7fff_ffff);
    issue(REQ_INSERT, 3,  -32'sd1);
    issue(REQ_REMOVE, 0,  32'sd0);
    issue(REQ_REMOVE, 2,  32'sd0);
    for (int k = 0; k < 14; k++) issue(REQ_APPEND, k, $urandom);
    issue(REQ_APPEND, 0,  32'sd9);
    issue(REQ_INSERT, 0,  32'sd9);
    issue(REQ_REMOVE, 17, 32'sd0);
    issue(REQ_REMOVE, 16, 32'sd0);

    trend_left = 0;
    burst_left = 0;
    for (int n = 0; n < 1925; n++) begin
      if (trend_left == 0) begin
        trend      = $urandom_range(0, 2);
        trend_left = $urandom_range(10, 60);
      end
      trend_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      offer_request(random_request(trend, shadow.held_count()));
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (shadow.outstanding() != 0 && wait_cycles < 20000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    if (shadow.outstanding() != 0) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      repeat (8) @(negedge clk_i);
      if (shadow.mismatches == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/plq_pkg.sv
rtl/plq_decode.sv
rtl/plq_store.sv
rtl/positional_list_queue.sv
bench/positional_list_queue_tb.sv
